// ===== rtl/spps_pkg.sv =====
// shared types and constants for the scripted pad playback sequencer
// used by spps_ctrl, spps_dp and scripted_pad_playback_sequencer_top
package spps_pkg;

    localparam int TABLE_DEPTH = 32;
    localparam int TBL_AW      = $clog2(TABLE_DEPTH);
    localparam int TBL_CW      = $clog2(TABLE_DEPTH + 1);
    localparam int POLL_W      = 25;
    localparam int DFLT_W      = 23;
    localparam logic [DFLT_W-1:0] DFLT_TIMEOUT = 23'd3600;
    localparam logic [4:0] MODE_MASK = 5'h1F;

    localparam logic [2:0] CMD_HOLD = 3'd0;
    localparam logic [2:0] CMD_WAIT = 3'd1;
    localparam logic [2:0] CMD_LOG  = 3'd2;
    localparam logic [2:0] CMD_SHOT = 3'd3;
    localparam logic [2:0] CMD_QUIT = 3'd4;

    typedef enum logic [3:0] {
        RES_OVERRIDE = 4'd0,
        RES_PASS     = 4'd1,
        RES_LOG      = 4'd2,
        RES_SHOT     = 4'd3,
        RES_QUIT     = 4'd4,
        RES_TIMEOUT  = 4'd5,
        RES_COMPLETE = 4'd6,
        RES_LOAD_OK  = 4'd7,
        RES_LOAD_REJ = 4'd8
    } t_res_kind;

    typedef enum logic [1:0] {
        PH_LOADING = 2'd0,
        PH_RUNNING = 2'd1,
        PH_DONE    = 2'd2
    } t_phase;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_APPEND,
        ST_FETCH,
        ST_EXEC,
        ST_COMPLETE,
        ST_PAD
    } t_state;

    typedef struct packed {
        logic      capture;
        logic      append;
        logic      start;
        logic      set_done;
        logic      mem_rd;
        logic      advance;
        logic      hold_run;
        logic      wait_run;
        logic      wait_neutral;
        logic      push;
        t_res_kind push_kind;
        logic      push_last;
    } t_dp_cmd;

    typedef struct packed {
        logic       slot_free;
        logic       func;
        logic       phase_done;
        logic       append_ok;
        logic       at_end;
        logic [2:0] cmd_kind;
        logic       hold_skip;
        logic       mode_match;
        logic       wait_timeout;
        logic       pad_set;
    } t_dp_sts;

endpackage

// ===== rtl/spps_ctrl.sv =====
// control state machine: walks the command table one entry at a time
// depends on spps_pkg; drives spps_dp through t_dp_cmd
module spps_ctrl import spps_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = ST_DISPATCH;
                end
            end
            ST_DISPATCH: begin
                if (!i_sts.func) begin
                    n_state = ST_APPEND;
                end else begin
                    o_cmd.start = 1'b1;
                    n_state     = i_sts.phase_done ? ST_PAD : ST_FETCH;
                end
            end
            ST_APPEND: begin
                if (i_sts.slot_free) begin
                    o_cmd.push      = 1'b1;
                    o_cmd.push_kind = i_sts.append_ok ? RES_LOAD_OK : RES_LOAD_REJ;
                    o_cmd.push_last = 1'b1;
                    o_cmd.append    = i_sts.append_ok;
                    n_state         = ST_IDLE;
                end
            end
            ST_FETCH: begin
                if (i_sts.at_end) begin
                    n_state = ST_COMPLETE;
                end else begin
                    o_cmd.mem_rd = 1'b1;
                    n_state      = ST_EXEC;
                end
            end
            ST_EXEC: begin
                case (i_sts.cmd_kind)
                    CMD_HOLD: begin
                        if (i_sts.hold_skip) begin
                            o_cmd.advance = 1'b1;
                            n_state       = ST_FETCH;
                        end else begin
                            o_cmd.hold_run = 1'b1;
                            n_state        = ST_PAD;
                        end
                    end
                    CMD_WAIT: begin
                        if (i_sts.mode_match) begin
                            o_cmd.wait_neutral = 1'b1;
                            o_cmd.advance      = 1'b1;
                            n_state            = ST_FETCH;
                        end else if (i_sts.wait_timeout) begin
                            if (i_sts.slot_free) begin
                                o_cmd.push         = 1'b1;
                                o_cmd.push_kind    = RES_TIMEOUT;
                                o_cmd.wait_neutral = 1'b1;
                                o_cmd.advance      = 1'b1;
                                n_state            = ST_FETCH;
                            end
                        end else begin
                            o_cmd.wait_neutral = 1'b1;
                            o_cmd.wait_run     = 1'b1;
                            n_state            = ST_PAD;
                        end
                    end
                    CMD_LOG, CMD_SHOT, CMD_QUIT: begin
                        if (i_sts.slot_free) begin
                            o_cmd.push    = 1'b1;
                            o_cmd.advance = 1'b1;
                            n_state       = ST_FETCH;
                            case (i_sts.cmd_kind)
                                CMD_LOG:  o_cmd.push_kind = RES_LOG;
                                CMD_SHOT: o_cmd.push_kind = RES_SHOT;
                                default:  o_cmd.push_kind = RES_QUIT;
                            endcase
                        end
                    end
                    default: begin
                        o_cmd.advance = 1'b1;
                        n_state       = ST_FETCH;
                    end
                endcase
            end
            ST_COMPLETE: begin
                if (i_sts.slot_free) begin
                    o_cmd.push      = 1'b1;
                    o_cmd.push_kind = RES_COMPLETE;
                    o_cmd.set_done  = 1'b1;
                    n_state         = ST_PAD;
                end
            end
            ST_PAD: begin
                if (i_sts.slot_free) begin
                    o_cmd.push      = 1'b1;
                    o_cmd.push_kind = i_sts.pad_set ? RES_OVERRIDE : RES_PASS;
                    o_cmd.push_last = 1'b1;
                    n_state         = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/spps_dp.sv =====
// datapath: command table memory, pointers, poll counter, pad and output registers
// depends on spps_pkg; steered by spps_ctrl through t_dp_cmd
module spps_dp import spps_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_dp_cmd             i_cmd,
    output t_dp_sts             o_sts,
    input  logic                i_cfg_we,
    input  logic [DFLT_W-1:0]   i_cfg_wdata,
    input  logic                i_func,
    input  logic [2:0]          i_cmd_kind,
    input  logic [15:0]         i_cmd_buttons,
    input  logic signed [7:0]   i_cmd_stick_x,
    input  logic signed [7:0]   i_cmd_stick_y,
    input  logic signed [23:0]  i_cmd_frames,
    input  logic [7:0]          i_cmd_target_mode,
    input  logic [7:0]          i_cmd_tag,
    input  logic [7:0]          i_game_mode,
    input  logic                i_out_ready,
    output logic                o_out_valid,
    output logic [3:0]          o_kind,
    output logic [15:0]         o_pad_buttons,
    output logic signed [7:0]   o_pad_stick_x,
    output logic signed [7:0]   o_pad_stick_y,
    output logic [7:0]          o_event_tag,
    output logic [4:0]          o_seen_mode,
    output logic                o_last
);

    logic [34:0] r_ctl_mem [TABLE_DEPTH];
    logic [39:0] r_pad_mem [TABLE_DEPTH];
    logic [34:0] r_ctl_rd;
    logic [39:0] r_pad_rd;

    logic        r_func;
    logic [2:0]  r_kind_in;
    logic [15:0] r_btn_in;
    logic [7:0]  r_x_in;
    logic [7:0]  r_y_in;
    logic [23:0] r_frames_in;
    logic [7:0]  r_target_in;
    logic [7:0]  r_tag_in;
    logic [4:0]  r_mode;

    logic [DFLT_W-1:0]        r_dflt;
    logic [TBL_CW-1:0]        r_count;
    logic [TBL_CW-1:0]        r_ptr;
    logic signed [POLL_W-1:0] r_cnt;
    t_phase                   r_phase;
    logic                     r_pad_set;
    logic [15:0]              r_pb;
    logic [7:0]               r_px;
    logic [7:0]               r_py;

    logic        r_out_valid;
    t_res_kind   r_out_kind;
    logic [15:0] r_out_btn;
    logic [7:0]  r_out_x;
    logic [7:0]  r_out_y;
    logic [7:0]  r_out_tag;
    logic [4:0]  r_out_seen;
    logic        r_out_last;

    logic [15:0] n_out_btn;
    logic [7:0]  n_out_x;
    logic [7:0]  n_out_y;
    logic [7:0]  n_out_tag;
    logic [4:0]  n_out_seen;

    logic signed [POLL_W-1:0] frames_s;
    logic signed [POLL_W-1:0] hold_next;
    logic signed [POLL_W-1:0] wait_next;
    logic signed [POLL_W-1:0] limit;
    logic [7:0]               want;
    logic                     slot_free;

    assign frames_s  = POLL_W'(signed'(r_ctl_rd[31:8]));
    assign want      = r_ctl_rd[7:0];
    assign hold_next = (r_cnt < 0) ? frames_s - POLL_W'(1) : r_cnt - POLL_W'(1);
    assign wait_next = (r_cnt < 0) ? POLL_W'(1) : r_cnt + POLL_W'(1);
    assign limit     = (frames_s > 0) ? frames_s : signed'(POLL_W'(r_dflt));
    assign slot_free = !r_out_valid || i_out_ready;

    always_comb begin
        o_sts              = '0;
        o_sts.slot_free    = slot_free;
        o_sts.func         = r_func;
        o_sts.phase_done   = (r_phase == PH_DONE);
        o_sts.append_ok    = (r_phase == PH_LOADING) && (r_count < TBL_CW'(TABLE_DEPTH))
                             && (r_kind_in inside {[CMD_HOLD:CMD_QUIT]});
        o_sts.at_end       = (r_ptr >= r_count);
        o_sts.cmd_kind     = r_ctl_rd[34:32];
        o_sts.hold_skip    = (frames_s <= 0);
        o_sts.mode_match   = ({3'b000, r_mode} == want);
        o_sts.wait_timeout = (wait_next >= limit);
        o_sts.pad_set      = r_pad_set;
    end

    // input word capture
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_func      <= i_func;
            r_kind_in   <= i_cmd_kind;
            r_btn_in    <= i_cmd_buttons;
            r_x_in      <= i_cmd_stick_x;
            r_y_in      <= i_cmd_stick_y;
            r_frames_in <= i_cmd_frames;
            r_target_in <= i_cmd_target_mode;
            r_tag_in    <= i_cmd_tag;
            r_mode      <= i_game_mode[4:0] & MODE_MASK;
        end
    end

    // command table
    always_ff @(posedge i_clk) begin
        if (i_cmd.append) begin
            r_ctl_mem[r_count[TBL_AW-1:0]] <= {r_kind_in, r_frames_in, r_target_in};
            r_pad_mem[r_count[TBL_AW-1:0]] <= {r_btn_in, r_x_in, r_y_in, r_tag_in};
        end
        if (i_cmd.mem_rd) begin
            r_ctl_rd <= r_ctl_mem[r_ptr[TBL_AW-1:0]];
            r_pad_rd <= r_pad_mem[r_ptr[TBL_AW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dflt <= DFLT_TIMEOUT;
        end else if (i_cfg_we) begin
            r_dflt <= i_cfg_wdata;
        end
    end

    // playback control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_ptr     <= '0;
            r_cnt     <= '1;
            r_phase   <= PH_LOADING;
            r_pad_set <= 1'b0;
        end else begin
            if (i_cmd.append) begin
                r_count <= r_count + 1'b1;
            end
            if (i_cmd.start) begin
                r_pad_set <= 1'b0;
                if (r_phase == PH_LOADING) begin
                    r_phase <= PH_RUNNING;
                    r_ptr   <= '0;
                    r_cnt   <= '1;
                end
            end
            if (i_cmd.set_done) begin
                r_phase <= PH_DONE;
            end
            if (i_cmd.wait_neutral) begin
                r_pad_set <= 1'b1;
            end
            if (i_cmd.wait_run) begin
                r_cnt <= wait_next;
            end
            if (i_cmd.hold_run) begin
                r_pad_set <= 1'b1;
                if (hold_next <= 0) begin
                    r_ptr <= r_ptr + 1'b1;
                    r_cnt <= '1;
                end else begin
                    r_cnt <= hold_next;
                end
            end
            if (i_cmd.advance) begin
                r_ptr <= r_ptr + 1'b1;
                r_cnt <= '1;
            end
        end
    end

    // pad values of the current poll
    always_ff @(posedge i_clk) begin
        if (i_cmd.wait_neutral) begin
            r_pb <= '0;
            r_px <= '0;
            r_py <= '0;
        end else if (i_cmd.hold_run) begin
            r_pb <= r_pad_rd[39:24];
            r_px <= r_pad_rd[23:16];
            r_py <= r_pad_rd[15:8];
        end
    end

    // result word register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.push) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_comb begin
        n_out_btn  = '0;
        n_out_x    = '0;
        n_out_y    = '0;
        n_out_tag  = '0;
        n_out_seen = '0;
        case (i_cmd.push_kind)
            RES_OVERRIDE: begin
                n_out_btn = r_pb;
                n_out_x   = r_px;
                n_out_y   = r_py;
            end
            RES_LOG, RES_SHOT: begin
                n_out_tag = r_pad_rd[7:0];
            end
            RES_TIMEOUT: begin
                n_out_tag  = want;
                n_out_seen = r_mode;
            end
            default: begin
                n_out_tag = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            r_out_kind <= i_cmd.push_kind;
            r_out_last <= i_cmd.push_last;
            r_out_btn  <= n_out_btn;
            r_out_x    <= n_out_x;
            r_out_y    <= n_out_y;
            r_out_tag  <= n_out_tag;
            r_out_seen <= n_out_seen;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_kind        = r_out_kind;
    assign o_pad_buttons = r_out_btn;
    assign o_pad_stick_x = r_out_x;
    assign o_pad_stick_y = r_out_y;
    assign o_event_tag   = r_out_tag;
    assign o_seen_mode   = r_out_seen;
    assign o_last        = r_out_last;

endmodule

// ===== rtl/scripted_pad_playback_sequencer_top.sv =====
// top level of the scripted pad playback sequencer
// depends on spps_pkg, spps_ctrl and spps_dp
//
//  channel   handshake                   payload
//  input     i_in_valid / o_in_ready     i_func, i_cmd_*, i_game_mode
//  output    o_out_valid / i_out_ready   o_kind, o_pad_*, o_event_tag, o_seen_mode, o_last
//  config    i_cfg_we                    i_cfg_wdata (default wait timeout)
//
// an append goes through the dispatch and append states; a poll goes through dispatch,
// then fetch and exec for each table entry walked, complete when the script ends in it,
// then pad; each entry is fetched through the registered read of the command table
// one word in flight at a time; ready returns once the final result word is registered
// a stalled output holds the sequencer in place; the next word may enter while it waits
// synchronous active-low reset clears the table count, pointer, phase and output valid
module scripted_pad_playback_sequencer_top import spps_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [DFLT_W-1:0]   i_cfg_wdata,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic                i_func,
    input  logic [2:0]          i_cmd_kind,
    input  logic [15:0]         i_cmd_buttons,
    input  logic signed [7:0]   i_cmd_stick_x,
    input  logic signed [7:0]   i_cmd_stick_y,
    input  logic signed [23:0]  i_cmd_frames,
    input  logic [7:0]          i_cmd_target_mode,
    input  logic [7:0]          i_cmd_tag,
    input  logic [7:0]          i_game_mode,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic [3:0]          o_kind,
    output logic [15:0]         o_pad_buttons,
    output logic signed [7:0]   o_pad_stick_x,
    output logic signed [7:0]   o_pad_stick_y,
    output logic [7:0]          o_event_tag,
    output logic [4:0]          o_seen_mode,
    output logic                o_last
);

    t_dp_cmd dp_cmd;
    t_dp_sts dp_sts;

    spps_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (dp_sts),
        .o_cmd      (dp_cmd)
    );

    spps_dp u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (dp_cmd),
        .o_sts             (dp_sts),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_wdata       (i_cfg_wdata),
        .i_func            (i_func),
        .i_cmd_kind        (i_cmd_kind),
        .i_cmd_buttons     (i_cmd_buttons),
        .i_cmd_stick_x     (i_cmd_stick_x),
        .i_cmd_stick_y     (i_cmd_stick_y),
        .i_cmd_frames      (i_cmd_frames),
        .i_cmd_target_mode (i_cmd_target_mode),
        .i_cmd_tag         (i_cmd_tag),
        .i_game_mode       (i_game_mode),
        .i_out_ready       (i_out_ready),
        .o_out_valid       (o_out_valid),
        .o_kind            (o_kind),
        .o_pad_buttons     (o_pad_buttons),
        .o_pad_stick_x     (o_pad_stick_x),
        .o_pad_stick_y     (o_pad_stick_y),
        .o_event_tag       (o_event_tag),
        .o_seen_mode       (o_seen_mode),
        .o_last            (o_last)
    );

    a_one_word_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("input accepted while a word is in progress");

    a_pad_zero_off_override: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_kind != RES_OVERRIDE)) |->
        (o_pad_buttons == 16'd0 && o_pad_stick_x == 8'sd0 && o_pad_stick_y == 8'sd0))
        else $error("pad fields set on a non-override result");

    a_load_result_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_kind == RES_LOAD_OK || o_kind == RES_LOAD_REJ)) |-> o_last)
        else $error("append result not marked last");

endmodule

// ===== tb/tb_scripted_pad_playback_sequencer_top.sv =====
`timescale 1ns / 100ps
// self-checking testbench for scripted_pad_playback_sequencer_top: loads a command script,
// then polls it under random stalls on both channels and compares every output word
// against a behavioral copy of the sequencer; depends on spps_pkg and the rtl
module tb_scripted_pad_playback_sequencer_top;
    import spps_pkg::*;

    localparam logic FUNC_APPEND = 1'b0;
    localparam logic FUNC_POLL   = 1'b1;
    localparam logic [2:0] CMD_RSV5 = 3'd5;
    localparam logic [2:0] CMD_RSV6 = 3'd6;
    localparam logic [2:0] CMD_RSV7 = 3'd7;
    localparam int ITEMS        = 430;
    localparam int CFG_EVERY    = 40;
    localparam int HOLDOFF_LEN  = 400;
    localparam int SETTLE       = 8;
    localparam int STALL_LIMIT  = 4000;

    typedef struct packed {
        logic              func;
        logic [2:0]        kind;
        logic [15:0]       buttons;
        logic [7:0]        sx;
        logic [7:0]        sy;
        logic signed [23:0] frames;
        logic [7:0]        target;
        logic [7:0]        tag;
        logic [7:0]        mode;
    } t_seq_word;

    typedef struct packed {
        t_res_kind   kind;
        logic [15:0] buttons;
        logic [7:0]  sx;
        logic [7:0]  sy;
        logic [7:0]  tag;
        logic [4:0]  seen;
        logic        last;
    } t_pad_result;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_cfg_we = 1'b0;
    logic [DFLT_W-1:0]  i_cfg_wdata = '0;
    logic               i_in_valid = 1'b0;
    logic               o_in_ready;
    logic               i_func = 1'b0;
    logic [2:0]         i_cmd_kind = '0;
    logic [15:0]        i_cmd_buttons = '0;
    logic signed [7:0]  i_cmd_stick_x = '0;
    logic signed [7:0]  i_cmd_stick_y = '0;
    logic signed [23:0] i_cmd_frames = '0;
    logic [7:0]         i_cmd_target_mode = '0;
    logic [7:0]         i_cmd_tag = '0;
    logic [7:0]         i_game_mode = '0;
    logic               o_out_valid;
    logic               i_out_ready = 1'b0;
    logic [3:0]         o_kind;
    logic [15:0]        o_pad_buttons;
    logic signed [7:0]  o_pad_stick_x;
    logic signed [7:0]  o_pad_stick_y;
    logic [7:0]         o_event_tag;
    logic [4:0]         o_seen_mode;
    logic               o_last;

    scripted_pad_playback_sequencer_top dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_wdata       (i_cfg_wdata),
        .i_in_valid        (i_in_valid),
        .o_in_ready        (o_in_ready),
        .i_func            (i_func),
        .i_cmd_kind        (i_cmd_kind),
        .i_cmd_buttons     (i_cmd_buttons),
        .i_cmd_stick_x     (i_cmd_stick_x),
        .i_cmd_stick_y     (i_cmd_stick_y),
        .i_cmd_frames      (i_cmd_frames),
        .i_cmd_target_mode (i_cmd_target_mode),
        .i_cmd_tag         (i_cmd_tag),
        .i_game_mode       (i_game_mode),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .o_kind            (o_kind),
        .o_pad_buttons     (o_pad_buttons),
        .o_pad_stick_x     (o_pad_stick_x),
        .o_pad_stick_y     (o_pad_stick_y),
        .o_event_tag       (o_event_tag),
        .o_seen_mode       (o_seen_mode),
        .o_last            (o_last)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // script table and playback state
    logic [2:0]         script_kind    [TABLE_DEPTH];
    logic signed [23:0] script_frames  [TABLE_DEPTH];
    logic [7:0]         script_target  [TABLE_DEPTH];
    logic [7:0]         script_tag     [TABLE_DEPTH];
    logic [15:0]        script_buttons [TABLE_DEPTH];
    logic [7:0]         script_sx      [TABLE_DEPTH];
    logic [7:0]         script_sy      [TABLE_DEPTH];
    int                 script_len = 0;
    int                 script_pos = 0;
    int                 poll_count = -1;
    t_phase             play_phase = PH_LOADING;
    int                 wait_default = int'(DFLT_TIMEOUT);

    t_pad_result pad_words_due[$];
    int          fail_cnt = 0;
    int          items_sent = 0;
    bit          rx_holdoff_req = 1'b0;

    function automatic t_pad_result pad_word(t_res_kind k, logic [15:0] b, logic [7:0] x,
                                             logic [7:0] y, logic [7:0] tg, logic [4:0] sn);
        t_pad_result r;
        r.kind = k;
        r.buttons = b;
        r.sx = x;
        r.sy = y;
        r.tag = tg;
        r.seen = sn;
        r.last = 1'b0;
        return r;
    endfunction

    task automatic step_sequencer(input t_seq_word w, output t_pad_result rw[$]);
        bit          pad_set;
        bit          busy;
        logic [15:0] pb;
        logic [7:0]  px;
        logic [7:0]  py;
        int          cur;
        int          fr;
        int          lim;
        rw = {};
        if (w.func == FUNC_APPEND) begin
            if (play_phase == PH_LOADING && script_len < TABLE_DEPTH && w.kind <= CMD_QUIT) begin
                script_kind[script_len]    = w.kind;
                script_frames[script_len]  = w.frames;
                script_target[script_len]  = w.target;
                script_tag[script_len]     = w.tag;
                script_buttons[script_len] = w.buttons;
                script_sx[script_len]      = w.sx;
                script_sy[script_len]      = w.sy;
                script_len++;
                rw.push_back(pad_word(RES_LOAD_OK, 0, 0, 0, 0, 0));
            end else begin
                rw.push_back(pad_word(RES_LOAD_REJ, 0, 0, 0, 0, 0));
            end
        end else if (play_phase == PH_DONE) begin
            rw.push_back(pad_word(RES_PASS, 0, 0, 0, 0, 0));
        end else begin
            cur = int'(w.mode[4:0] & MODE_MASK);
            if (play_phase == PH_LOADING) begin
                play_phase = PH_RUNNING;
                script_pos = 0;
                poll_count = -1;
            end
            pad_set = 1'b0;
            busy = 1'b1;
            pb = '0;
            px = '0;
            py = '0;
            while (busy) begin
                if (script_pos >= script_len) begin
                    rw.push_back(pad_word(RES_COMPLETE, 0, 0, 0, 0, 0));
                    play_phase = PH_DONE;
                    busy = 1'b0;
                end else begin
                    fr = script_frames[script_pos];
                    case (script_kind[script_pos])
                        CMD_HOLD: begin
                            if (fr <= 0) begin
                                script_pos++;
                                poll_count = -1;
                            end else begin
                                if (poll_count < 0)
                                    poll_count = fr;
                                pb = script_buttons[script_pos];
                                px = script_sx[script_pos];
                                py = script_sy[script_pos];
                                pad_set = 1'b1;
                                poll_count--;
                                if (poll_count <= 0) begin
                                    script_pos++;
                                    poll_count = -1;
                                end
                                busy = 1'b0;
                            end
                        end
                        CMD_WAIT: begin
                            pb = '0;
                            px = '0;
                            py = '0;
                            pad_set = 1'b1;
                            if (cur == int'(script_target[script_pos])) begin
                                script_pos++;
                                poll_count = -1;
                            end else begin
                                if (poll_count < 0)
                                    poll_count = 0;
                                poll_count++;
                                lim = (fr > 0) ? fr : wait_default;
                                if (poll_count >= lim) begin
                                    rw.push_back(pad_word(RES_TIMEOUT, 0, 0, 0,
                                                          script_target[script_pos], cur[4:0]));
                                    script_pos++;
                                    poll_count = -1;
                                end else begin
                                    busy = 1'b0;
                                end
                            end
                        end
                        CMD_LOG: begin
                            rw.push_back(pad_word(RES_LOG, 0, 0, 0, script_tag[script_pos], 0));
                            script_pos++;
                        end
                        CMD_SHOT: begin
                            rw.push_back(pad_word(RES_SHOT, 0, 0, 0, script_tag[script_pos], 0));
                            script_pos++;
                        end
                        default: begin
                            rw.push_back(pad_word(RES_QUIT, 0, 0, 0, 0, 0));
                            script_pos++;
                        end
                    endcase
                end
            end
            if (pad_set)
                rw.push_back(pad_word(RES_OVERRIDE, pb, px, py, 0, 0));
            else
                rw.push_back(pad_word(RES_PASS, 0, 0, 0, 0, 0));
        end
        rw[rw.size()-1].last = 1'b1;
    endtask

    // mode of the wait the next poll will reach, or -1
    function automatic int waited_mode();
        int p;
        p = script_pos;
        while (p < script_len) begin
            if (script_kind[p] == CMD_WAIT)
                return (script_target[p] <= 8'd31) ? int'(script_target[p]) : -1;
            if (script_kind[p] == CMD_HOLD && script_frames[p] > 0)
                return -1;
            p++;
        end
        return -1;
    endfunction

    function automatic t_seq_word cmd(logic f, logic [2:0] k, logic [15:0] b, logic [7:0] x,
                                      logic [7:0] y, logic [23:0] fr, logic [7:0] tgt,
                                      logic [7:0] tg, logic [7:0] md);
        t_seq_word w;
        w.func = f;
        w.kind = k;
        w.buttons = b;
        w.sx = x;
        w.sy = y;
        w.frames = fr;
        w.target = tgt;
        w.tag = tg;
        w.mode = md;
        return w;
    endfunction

    function automatic t_seq_word rand_append();
        t_seq_word w;
        int r;
        w = cmd(FUNC_APPEND, CMD_HOLD, 16'($urandom), 8'($urandom), 8'($urandom),
                24'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
        r = $urandom_range(0, 99);
        if (r < 40)
            w.kind = CMD_HOLD;
        else if (r < 65)
            w.kind = CMD_WAIT;
        else if (r < 77)
            w.kind = CMD_LOG;
        else if (r < 89)
            w.kind = CMD_SHOT;
        else if (r < 95)
            w.kind = CMD_QUIT;
        else
            w.kind = 3'($urandom_range(CMD_RSV5, CMD_RSV7));
        r = $urandom_range(0, 99);
        if (w.kind == CMD_HOLD) begin
            if (r < 12)
                w.frames = '0;
            else if (r < 22)
                w.frames = 24'($urandom | 32'h0080_0000);
            else if (r < 85)
                w.frames = 24'($urandom_range(1, 8));
            else
                w.frames = 24'($urandom_range(9, 30));
        end else if (w.kind == CMD_WAIT) begin
            w.target = ($urandom_range(0, 3) != 0) ? 8'($urandom_range(0, 31))
                                                   : 8'($urandom_range(32, 255));
            if (r < 40)
                w.frames = 24'($urandom_range(1, 10));
            else if (r < 60)
                w.frames = (r < 50) ? 24'sd0 : 24'($urandom | 32'h0080_0000);
            else if (r < 80 || w.target > 8'd31)
                w.frames = 24'($urandom_range(11, 40));
            else
                w.frames = 24'($urandom_range(41, 8388607));
        end
        return w;
    endfunction

    function automatic int sender_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 95)
            return $urandom_range(4, 10);
        return $urandom_range(20, 50);
    endfunction

    function automatic logic [DFLT_W-1:0] wait_default_for(int k);
        case (k % 6)
            0: return '0;
            1: return '1;
            2: return 23'd1;
            3: return DFLT_TIMEOUT;
            4: return 23'd5;
            default: return 23'($urandom_range(1, 40));
        endcase
    endfunction

    task automatic send_word(input t_seq_word w, input bit typed, input t_res_kind typed_kind);
        t_pad_result rw[$];
        t_pad_result t;
        int gap;
        i_in_valid <= 1'b1;
        i_func <= w.func;
        i_cmd_kind <= w.kind;
        i_cmd_buttons <= w.buttons;
        i_cmd_stick_x <= w.sx;
        i_cmd_stick_y <= w.sy;
        i_cmd_frames <= w.frames;
        i_cmd_target_mode <= w.target;
        i_cmd_tag <= w.tag;
        i_game_mode <= w.mode;
        @(posedge i_clk);
        while (!o_in_ready)
            @(posedge i_clk);
        step_sequencer(w, rw);
        if (typed) begin
            t = pad_word(typed_kind, 0, 0, 0, 0, 0);
            t.last = 1'b1;
            pad_words_due.push_back(t);
        end else begin
            foreach (rw[i])
                pad_words_due.push_back(rw[i]);
        end
        items_sent++;
        gap = sender_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        while (pad_words_due.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic set_wait_default(input logic [DFLT_W-1:0] v);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        wait_default = int'(v);
        i_cfg_we <= 1'b0;
    endtask

    task automatic cmp_field(input string nm, input logic [15:0] e, input logic [15:0] a);
        if (a !== e) begin
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, nm, e, a);
            fail_cnt++;
        end
    endtask

    task automatic check_word();
        t_pad_result e;
        if (pad_words_due.size() == 0) begin
            $display("%0t: unexpected word, expected none, got kind %0d", $time, o_kind);
            fail_cnt++;
        end else begin
            e = pad_words_due.pop_front();
            cmp_field("kind", e.kind, o_kind);
            cmp_field("pad_buttons", e.buttons, o_pad_buttons);
            cmp_field("pad_stick_x", e.sx, unsigned'(o_pad_stick_x));
            cmp_field("pad_stick_y", e.sy, unsigned'(o_pad_stick_y));
            cmp_field("event_tag", e.tag, o_event_tag);
            cmp_field("seen_mode", e.seen, o_seen_mode);
            cmp_field("last", e.last, o_last);
        end
    endtask

    // output side: random ready with bursts, gaps and one long hold-off
    int rx_ready_left = 0;
    int rx_gap_left = 0;
    int rx_holdoff_left = 0;

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready)
                check_word();
            if (rx_holdoff_req) begin
                rx_holdoff_req = 1'b0;
                rx_holdoff_left = HOLDOFF_LEN;
            end
            if (rx_holdoff_left > 0) begin
                rx_holdoff_left--;
                i_out_ready <= 1'b0;
            end else begin
                if (rx_ready_left == 0 && rx_gap_left == 0) begin
                    case ($urandom_range(0, 19))
                        0, 1: rx_gap_left = $urandom_range(20, 60);
                        2, 3, 4: rx_gap_left = $urandom_range(4, 12);
                        5, 6, 7, 8, 9: rx_gap_left = $urandom_range(1, 3);
                        default: rx_gap_left = 0;
                    endcase
                    rx_ready_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 150)
                                                               : $urandom_range(1, 12);
                end
                if (rx_gap_left > 0) begin
                    rx_gap_left--;
                    i_out_ready <= 1'b0;
                end else begin
                    rx_ready_left--;
                    i_out_ready <= 1'b1;
                end
            end
        end
    end

    int idle_cycles = 0;

    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) || !i_rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("tb_scripted_pad_playback_sequencer_top: FAIL");
            $finish;
        end
    end

    initial begin
        t_seq_word dir_rows[$];
        t_res_kind dir_kinds[$];
        t_seq_word w;
        int hint;
        int poll_items;

        dir_rows.push_back(cmd(FUNC_APPEND, CMD_HOLD, 16'hFFFF, 8'h7F, 8'h80, 24'd3,
                               8'h00, 8'h00, 8'h00));
        dir_kinds.push_back(RES_LOAD_OK);
        dir_rows.push_back(cmd(FUNC_APPEND, CMD_HOLD, 16'h0000, 8'h80, 8'h7F, 24'd0,
                               8'h00, 8'h00, 8'h00));
        dir_kinds.push_back(RES_LOAD_OK);
        dir_rows.push_back(cmd(FUNC_APPEND, CMD_HOLD, 16'hAAAA, 8'h01, 8'hFF, 24'h800000,
                               8'h00, 8'h00, 8'h00));
        dir_kinds.push_back(RES_LOAD_OK);
        dir_rows.push_back(cmd(FUNC_APPEND, CMD_LOG, 16'h0000, 8'h00, 8'h00, 24'd0,
                               8'h00, 8'hFF, 8'h00));
        dir_kinds.push_back(RES_LOAD_OK);
        dir_rows.push_back(cmd(FUNC_APPEND, CMD_SHOT, 16'h0000, 8'h00, 8'h00, 24'd0,
                               8'h00, 8'h5A, 8'h00));
        dir_kinds.push_back(RES_LOAD_OK);
        dir_rows.push_back(cmd(FUNC_APPEND, CMD_QUIT, 16'h0000, 8'h00, 8'h00, 24'd0,
                               8'h00, 8'h00, 8'h00));
        dir_kinds.push_back(RES_LOAD_OK);
        dir_rows.push_back(cmd(FUNC_APPEND, CMD_WAIT, 16'h0000, 8'h00, 8'h00, 24'h7FFFFF,
                               8'h0A, 8'h00, 8'h00));
        dir_kinds.push_back(RES_LOAD_OK);
        dir_rows.push_back(cmd(FUNC_APPEND, CMD_WAIT, 16'h0000, 8'h00, 8'h00, 24'd2,
                               8'hFF, 8'h00, 8'h00));
        dir_kinds.push_back(RES_LOAD_OK);
        dir_rows.push_back(cmd(FUNC_APPEND, CMD_WAIT, 16'h0000, 8'h00, 8'h00, 24'd0,
                               8'h03, 8'h00, 8'h00));
        dir_kinds.push_back(RES_LOAD_OK);
        dir_rows.push_back(cmd(FUNC_APPEND, CMD_WAIT, 16'h0000, 8'h00, 8'h00, 24'hFFFFFB,
                               8'h1F, 8'h00, 8'h00));
        dir_kinds.push_back(RES_LOAD_OK);
        dir_rows.push_back(cmd(FUNC_APPEND, CMD_RSV5, 16'h1234, 8'h00, 8'h00, 24'd4,
                               8'h00, 8'h00, 8'h00));
        dir_kinds.push_back(RES_LOAD_REJ);
        dir_rows.push_back(cmd(FUNC_APPEND, CMD_RSV6, 16'h0000, 8'h00, 8'h00, 24'd4,
                               8'h00, 8'h00, 8'h00));
        dir_kinds.push_back(RES_LOAD_REJ);
        dir_rows.push_back(cmd(FUNC_APPEND, CMD_RSV7, 16'h0000, 8'h00, 8'h00, 24'd4,
                               8'h00, 8'h00, 8'h00));
        dir_kinds.push_back(RES_LOAD_REJ);
        dir_rows.push_back(cmd(FUNC_APPEND, CMD_HOLD, 16'h5555, 8'h00, 8'h00, 24'd1,
                               8'h00, 8'h00, 8'h00));
        dir_kinds.push_back(RES_LOAD_OK);
        dir_rows.push_back(cmd(FUNC_APPEND, CMD_LOG, 16'h0000, 8'h00, 8'h00, 24'd0,
                               8'h00, 8'h00, 8'h00));
        dir_kinds.push_back(RES_LOAD_OK);

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        set_wait_default('1);

        foreach (dir_rows[i])
            send_word(dir_rows[i], 1'b1, dir_kinds[i]);

        drain();
        set_wait_default(DFLT_TIMEOUT);

        // fill the table; the last slot is a wait that can only time out
        while (script_len < TABLE_DEPTH - 1)
            send_word(rand_append(), 1'b0, RES_PASS);
        send_word(cmd(FUNC_APPEND, CMD_WAIT, 16'($urandom), 8'($urandom), 8'($urandom),
                      24'd3, 8'hC8, 8'($urandom), 8'($urandom)), 1'b0, RES_PASS);
        repeat (4) send_word(rand_append(), 1'b0, RES_PASS);

        poll_items = 0;
        while (items_sent < ITEMS) begin
            if (poll_items % CFG_EVERY == 0) begin
                drain();
                set_wait_default(wait_default_for(poll_items / CFG_EVERY));
            end
            if ($urandom_range(0, 9) == 0) begin
                w = rand_append();
            end else begin
                w = cmd(FUNC_POLL, 3'($urandom), 16'($urandom), 8'($urandom), 8'($urandom),
                        24'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
                hint = waited_mode();
                if (hint >= 0 && $urandom_range(0, 99) < 45)
                    w.mode = {3'($urandom), 5'(hint)};
            end
            send_word(w, 1'b0, RES_PASS);
            poll_items++;
            if (poll_items == CFG_EVERY / 2)
                rx_holdoff_req = 1'b1;
        end

        drain();
        repeat (20) @(posedge i_clk);
        if (fail_cnt == 0)
            $display("tb_scripted_pad_playback_sequencer_top: PASS");
        else
            $display("tb_scripted_pad_playback_sequencer_top: FAIL");
        $finish;
    end

endmodule

// ===== scripted_pad_playback_sequencer_top.f =====
rtl/spps_pkg.sv
rtl/spps_ctrl.sv
rtl/spps_dp.sv
rtl/scripted_pad_playback_sequencer_top.sv
tb/tb_scripted_pad_playback_sequencer_top.sv
